// ===== sv/contactor_frame_crc8_gen_unit_macros.svh =====
// Assertion macros for the contactor frame generator.
// Used by the top level only; no other dependencies.
`ifndef CONTACTOR_FRAME_CRC8_GEN_UNIT_MACROS_SVH
`define CONTACTOR_FRAME_CRC8_GEN_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CFCRC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cfcrc assertion failed");
`define CFCRC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfcrc assertion failed");
`else
`define CFCRC_ASSERT(name, prop)
`define CFCRC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== sv/cfcrc_pkg.sv =====
// Shared types, constants and frame helpers for the contactor frame generator.
// No dependencies; used by every module of the block.
package cfcrc_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned OutDataW   = 104;

  localparam logic [28:0] CanIdContactor = 29'h00000BA;
  localparam logic [28:0] CanIdHeartbeat = 29'h1BFFDA19;
  localparam logic [3:0]  CountContactor = 4'd8;
  localparam logic [3:0]  CountHeartbeat = 4'd2;

  localparam logic [7:0] CrcPoly   = 8'h2F;
  localparam logic [7:0] CrcInit   = 8'hFF;
  localparam logic [7:0] CrcXorout = 8'hFF;
  localparam logic [7:0] Byte1Run  = 8'h50;
  localparam logic [7:0] Byte1Pre  = 8'h10;
  localparam logic [7:0] Byte2Off  = 8'h28;
  localparam logic [7:0] Byte2On   = 8'h29;
  localparam logic [7:0] Byte7Val  = 8'h26;

  localparam logic [7:0] HbPeriodReset = 8'd100;

  localparam logic [2:0] RegAddrHbPeriod = 3'd0;

  typedef enum logic [1:0] {
    ClsOff = 2'd0,
    ClsPre = 2'd1,
    ClsRun = 2'd2
  } mode_cls_e;

  typedef enum logic [2:0] {
    ModeOff     = 3'd0,
    ModeRun     = 3'd1,
    ModePre     = 3'd2,
    ModePreFail = 3'd3,
    ModeCharge  = 3'd4
  } op_mode_e;

  typedef struct packed {
    logic      hb;
    mode_cls_e cls;
    logic [3:0] alive;
  } queue_entry_t;

  typedef struct packed {
    logic hb_pending;
  } back_status_t;

  typedef logic [15:0][7:0] magic_tab_t;
  typedef logic [63:0][7:0] crc_tab_t;

  localparam magic_tab_t MagicTab = {
    8'h70, 8'hF6, 8'h76, 8'hF1, 8'h8C, 8'h73, 8'h2A, 8'h13,
    8'h4F, 8'hDF, 8'h38, 8'h39, 8'hCF, 8'h01, 8'hAA, 8'h6C
  };

  function automatic logic [7:0] frame_byte1(mode_cls_e cls, logic [3:0] alive);
    logic [7:0] b;
    b = {4'h0, alive};
    unique case (cls)
      ClsRun:  b = b | Byte1Run;
      ClsPre:  b = b | Byte1Pre;
      default: b = b;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] frame_byte2(mode_cls_e cls);
    return (cls == ClsRun || cls == ClsPre) ? Byte2On : Byte2Off;
  endfunction

  function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic crc_tab_t build_crc_tab();
    crc_tab_t   t;
    logic [7:0] c;
    logic [5:0] ix;
    for (int i = 0; i < 64; i++) begin
      ix = i[5:0];
      c = CrcInit;
      c = crc_byte(c, frame_byte1(mode_cls_e'(ix[5:4]), ix[3:0]));
      c = crc_byte(c, frame_byte2(mode_cls_e'(ix[5:4])));
      c = crc_byte(c, 8'h00);
      c = crc_byte(c, 8'h00);
      c = crc_byte(c, 8'h00);
      c = crc_byte(c, 8'h00);
      c = crc_byte(c, Byte7Val);
      c = crc_byte(c, MagicTab[ix[3:0]]);
      t[i] = c ^ CrcXorout;
    end
    return t;
  endfunction

  localparam crc_tab_t CrcTab = build_crc_tab();

endpackage

// ===== sv/contactor_frame_crc8_gen_unit.sv =====
// Top level of the contactor frame generator: config register, front, queue, back.
// Depends on cfcrc_pkg, cfcrc_front, cfcrc_queue, cfcrc_back and the macros header.
//
// Each transaction on the s_axis side is one scheduler tick carrying op_mode.
// Each tick yields one 8-byte contactor frame (tlast high) on m_axis, preceded
// by a 2-byte all-zero heartbeat frame (tlast low) once every heartbeat_period
// ticks. heartbeat_period is written over the APB port at address 0.
// A tick is written into the queue, then loaded into the output register that sends
// its first frame. Throughput: one frame per cycle on m_axis while m_axis_tready
// is high, so one tick per cycle without a heartbeat, and a tick with one sends two
// frames; the output register is the single result port that sets this rate.
// A two-entry queue parts the tick counters from the frame builder, so ticks
// keep being taken while a finished frame waits for m_axis_tready.
// When the receiver stalls, the frame is held and the queue fills; s_axis_tready
// drops once the queue is full.
// Reset clears both counters, empties the queue and output, and sets
// heartbeat_period to 100.
`include "contactor_frame_crc8_gen_unit_macros.svh"
module contactor_frame_crc8_gen_unit #(
  parameter int unsigned QUEUE_DEPTH = cfcrc_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [2:0] op_mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [28:0] can_id, [32:29] byte_count,
                                       // [64:33] payload_low, [96:65] payload_high
  output logic         m_axis_tlast,   // last_frame
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [7:0] period_q, period_d;
  logic       period_sel;
  logic       push, pop, q_ready, q_valid;
  cfcrc_pkg::queue_entry_t entry, head;
  cfcrc_pkg::back_status_t bstat;

  assign pready     = 1'b1;
  assign period_sel = (paddr[2] == cfcrc_pkg::RegAddrHbPeriod[2]);
  assign prdata     = period_sel ? {24'h000000, period_q} : 32'h0;

  always_comb begin
    period_d = period_q;
    if (psel && penable && pwrite && pready && period_sel) begin
      period_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= cfcrc_pkg::HbPeriodReset;
    end else begin
      period_q <= period_d;
    end
  end

  cfcrc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_mode_i  (s_axis_tdata[2:0]),
    .period_i   (period_q),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .entry_o    (entry)
  );

  cfcrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  cfcrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .status_o    (bstat)
  );

  `CFCRC_ASSERT(a_hb_pending_head, bstat.hb_pending |-> (q_valid && head.hb))
  `CFCRC_ASSERT(a_frame_byte7, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[96:89] == cfcrc_pkg::Byte7Val))
  `CFCRC_ASSERT(a_hb_not_last, (m_axis_tvalid && m_axis_tdata[32:29] == cfcrc_pkg::CountHeartbeat) |-> !m_axis_tlast)
  `CFCRC_ASSERT_NEXT(a_hb_then_frame, m_axis_tvalid && m_axis_tready && !m_axis_tlast, bstat.hb_pending == 1'b0 || q_valid)

endmodule

// ===== sv/cfcrc_front.sv =====
// Front end: accepts ticks, keeps the tick and alive counters, classifies the mode.
// Depends on cfcrc_pkg.
module cfcrc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              op_mode_i,
  input  logic [7:0]              period_i,
  input  logic                    q_ready_i,
  output logic                    push_o,
  output cfcrc_pkg::queue_entry_t entry_o
);

  logic [7:0] tick_q, tick_d, tick_inc;
  logic [3:0] alive_q, alive_d;
  logic       hb;
  cfcrc_pkg::mode_cls_e cls;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;
  assign tick_inc   = tick_q + 8'd1;
  assign hb         = (tick_inc == period_i);

  always_comb begin
    unique case (cfcrc_pkg::op_mode_e'(op_mode_i))
      cfcrc_pkg::ModeRun, cfcrc_pkg::ModeCharge: cls = cfcrc_pkg::ClsRun;
      cfcrc_pkg::ModePre:                        cls = cfcrc_pkg::ClsPre;
      default:                                   cls = cfcrc_pkg::ClsOff;
    endcase
  end

  always_comb begin
    tick_d  = tick_q;
    alive_d = alive_q;
    if (push_o) begin
      tick_d  = hb ? 8'd0 : tick_inc;
      alive_d = alive_q + 4'd1;
    end
  end

  assign entry_o = '{hb: hb, cls: cls, alive: alive_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      alive_q <= '0;
    end else begin
      tick_q  <= tick_d;
      alive_q <= alive_d;
    end
  end

endmodule

// ===== sv/cfcrc_queue.sv =====
// Short queue of classified ticks between the front and back ends.
// Depends on cfcrc_pkg.
module cfcrc_queue #(
  parameter int unsigned DEPTH = cfcrc_pkg::QueueDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  cfcrc_pkg::queue_entry_t entry_i,
  output logic                    ready_o,
  input  logic                    pop_i,
  output logic                    valid_o,
  output cfcrc_pkg::queue_entry_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cfcrc_pkg::queue_entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign ready_o = (cnt_q != CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/cfcrc_back.sv =====
// Back end: builds heartbeat and contactor frames with CRC, holds the output register.
// Depends on cfcrc_pkg.
module cfcrc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  cfcrc_pkg::queue_entry_t             head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [cfcrc_pkg::OutDataW-1:0]      out_data_o,
  output logic                                out_last_o,
  output cfcrc_pkg::back_status_t             status_o
);

  logic       valid_q, valid_d;
  logic       hb_sent_q, hb_sent_d;
  logic       load, send_hb;
  logic [cfcrc_pkg::OutDataW-1:0] data_q, data_d;
  logic       last_q, last_d;
  logic [7:0] crc, b1, b2;
  logic [31:0] pay_lo, pay_hi;

  assign load    = q_valid_i && (!valid_q || out_ready_i);
  assign send_hb = head_i.hb && !hb_sent_q;
  assign pop_o   = load && !send_hb;

  assign crc    = cfcrc_pkg::CrcTab[{head_i.cls, head_i.alive}];
  assign b1     = cfcrc_pkg::frame_byte1(head_i.cls, head_i.alive);
  assign b2     = cfcrc_pkg::frame_byte2(head_i.cls);
  assign pay_lo = {8'h00, b2, b1, crc};
  assign pay_hi = {cfcrc_pkg::Byte7Val, 24'h000000};

  always_comb begin
    valid_d   = valid_q;
    hb_sent_d = hb_sent_q;
    data_d    = data_q;
    last_d    = last_q;
    if (load) begin
      valid_d = 1'b1;
      if (send_hb) begin
        hb_sent_d = 1'b1;
        last_d    = 1'b0;
        data_d    = {7'h00, 32'h0, 32'h0, cfcrc_pkg::CountHeartbeat,
                     cfcrc_pkg::CanIdHeartbeat};
      end else begin
        hb_sent_d = 1'b0;
        last_d    = 1'b1;
        data_d    = {7'h00, pay_hi, pay_lo, cfcrc_pkg::CountContactor,
                     cfcrc_pkg::CanIdContactor};
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      hb_sent_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      hb_sent_q <= hb_sent_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;
  assign status_o    = '{hb_pending: hb_sent_q};

endmodule

// ===== bench/tb_contactor_frame_crc8_gen_unit.sv =====
// Self-checking bench for contactor_frame_crc8_gen_unit: drives ticks over the stream input,
// writes heartbeat_period over APB and checks every frame against an in-bench frame predictor.
// Depends on cfcrc_pkg and the block's RTL only.
module tb_contactor_frame_crc8_gen_unit;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 80;
  // codes outside the named modes, all treated as off
  localparam logic [2:0]  ModeSpare5 = 3'd5;
  localparam logic [2:0]  ModeSpare6 = 3'd6;
  localparam logic [2:0]  ModeSpare7 = 3'd7;

  typedef struct packed {
    logic [28:0] can_id;
    logic [3:0]  byte_count;
    logic [31:0] pay_lo;
    logic [31:0] pay_hi;
    logic        last;
  } frame_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] b1;
    logic [7:0] b2;
  } dir_row_t;

  localparam dir_row_t DirTab [20] = '{
    '{cfcrc_pkg::ModeOff,     8'h00, 8'h28},
    '{cfcrc_pkg::ModeRun,     8'h51, 8'h29},
    '{cfcrc_pkg::ModePre,     8'h12, 8'h29},
    '{cfcrc_pkg::ModePreFail, 8'h03, 8'h28},
    '{cfcrc_pkg::ModeCharge,  8'h54, 8'h29},
    '{ModeSpare5,             8'h05, 8'h28},
    '{ModeSpare6,             8'h06, 8'h28},
    '{ModeSpare7,             8'h07, 8'h28},
    '{cfcrc_pkg::ModeRun,     8'h58, 8'h29},
    '{cfcrc_pkg::ModeCharge,  8'h59, 8'h29},
    '{cfcrc_pkg::ModePre,     8'h1A, 8'h29},
    '{cfcrc_pkg::ModeOff,     8'h0B, 8'h28},
    '{ModeSpare7,             8'h0C, 8'h28},
    '{cfcrc_pkg::ModeRun,     8'h5D, 8'h29},
    '{cfcrc_pkg::ModePre,     8'h1E, 8'h29},
    '{cfcrc_pkg::ModeCharge,  8'h5F, 8'h29},
    '{cfcrc_pkg::ModeOff,     8'h00, 8'h28},
    '{cfcrc_pkg::ModeRun,     8'h51, 8'h29},
    '{cfcrc_pkg::ModePreFail, 8'h02, 8'h28},
    '{ModeSpare5,             8'h03, 8'h28}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  contactor_frame_crc8_gen_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk_i = ~clk_i;

  frame_t      exp_frames [$];
  logic [7:0]  hb_period;
  logic [7:0]  hb_ticks;
  logic [3:0]  alive_cnt;
  int          err_count = 0;
  int          ticks_sent = 0;
  int          frames_seen = 0;
  int          hb_seen = 0;
  int          periods_written = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned cycles = 0;

  function automatic logic [7:0] crc8_upd(logic [7:0] crc, logic [7:0] d);
    logic [7:0] r;
    r = crc ^ d;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ cfcrc_pkg::CrcPoly) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  task automatic predict_tick(input logic [2:0] mode, input logic typed,
                              input logic [7:0] tb1, input logic [7:0] tb2);
    frame_t     f;
    logic [7:0] fb [8];
    logic [7:0] crc;
    hb_ticks = hb_ticks + 8'd1;
    if (hb_ticks == hb_period) begin
      f = '{cfcrc_pkg::CanIdHeartbeat, cfcrc_pkg::CountHeartbeat, 32'h0, 32'h0, 1'b0};
      exp_frames.push_back(f);
      hb_ticks = 8'd0;
    end
    for (int i = 0; i < 8; i++) fb[i] = 8'h00;
    fb[1] = {4'h0, alive_cnt};
    fb[2] = cfcrc_pkg::Byte2Off;
    fb[7] = cfcrc_pkg::Byte7Val;
    case (mode)
      cfcrc_pkg::ModeRun, cfcrc_pkg::ModeCharge: begin
        fb[1] = fb[1] | cfcrc_pkg::Byte1Run;
        fb[2] = cfcrc_pkg::Byte2On;
      end
      cfcrc_pkg::ModePre: begin
        fb[1] = fb[1] | cfcrc_pkg::Byte1Pre;
        fb[2] = cfcrc_pkg::Byte2On;
      end
      default: ;
    endcase
    crc = cfcrc_pkg::CrcInit;
    for (int i = 1; i < 8; i++) crc = crc8_upd(crc, fb[i]);
    crc = crc8_upd(crc, cfcrc_pkg::MagicTab[alive_cnt]);
    fb[0] = crc ^ cfcrc_pkg::CrcXorout;
    if (typed) begin
      fb[1] = tb1;
      fb[2] = tb2;
    end
    f = '{cfcrc_pkg::CanIdContactor, cfcrc_pkg::CountContactor,
          {fb[3], fb[2], fb[1], fb[0]}, {fb[7], fb[6], fb[5], fb[4]}, 1'b1};
    exp_frames.push_back(f);
    alive_cnt = alive_cnt + 4'd1;
  endtask

  task automatic send_tick(input logic [2:0] mode, input logic typed,
                           input logic [7:0] tb1, input logic [7:0] tb2);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_tick(mode, typed, tb1, tb2);
    ticks_sent++;
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_tick(3'($urandom_range(7)), 1'b0, 8'h00, 8'h00);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (exp_frames.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cfcrc_pkg::RegAddrHbPeriod;
    pwdata  <= {24'h0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    hb_period = val;
    periods_written++;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== val) begin
      $error("heartbeat_period readback: expected %h, got %h", val, prdata[7:0]);
      err_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    frame_t e;
    frame_t a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a = '{m_axis_tdata[28:0], m_axis_tdata[32:29], m_axis_tdata[64:33],
            m_axis_tdata[96:65], m_axis_tlast};
      if (exp_frames.size() == 0) begin
        $error("frame with no expectation: can_id %h", a.can_id);
        err_count++;
      end else begin
        e = exp_frames.pop_front();
        frames_seen++;
        if (!e.last) hb_seen++;
        if (a.can_id !== e.can_id) begin
          $error("can_id: expected %h, got %h", e.can_id, a.can_id);
          err_count++;
        end
        if (a.byte_count !== e.byte_count) begin
          $error("byte_count: expected %0d, got %0d", e.byte_count, a.byte_count);
          err_count++;
        end
        if (a.pay_lo !== e.pay_lo) begin
          $error("payload_low: expected %h, got %h", e.pay_lo, a.pay_lo);
          err_count++;
        end
        if (a.pay_hi !== e.pay_hi) begin
          $error("payload_high: expected %h, got %h", e.pay_hi, a.pay_hi);
          err_count++;
        end
        if (a.last !== e.last) begin
          $error("last_frame: expected %b, got %b", e.last, a.last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_contactor_frame_crc8_gen_unit failed");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = cfcrc_pkg::RegAddrHbPeriod;
    pwdata        = 32'h0;
    hb_period     = cfcrc_pkg::HbPeriodReset;
    hb_ticks      = 8'd0;
    alive_cnt     = 4'd0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset state, every mode, alive counter wrap
    foreach (DirTab[i]) send_tick(DirTab[i].mode, 1'b1, DirTab[i].b1, DirTab[i].b2);
    drain();

    // period 1 under running count: no heartbeat; long receiver hold-off fills the block
    write_period(8'd1);
    hold_reqs++;
    send_random(40);
    drain();

    src_idle_pct = 69;
    write_period(8'd255);
    send_random(260);
    drain();

    // period zero: heartbeat only when the count wraps
    src_idle_pct   = 0;
    sink_stall_pct = 69;
    write_period(8'd0);
    send_random(260);
    drain();

    src_idle_pct   = 34;
    sink_stall_pct = 34;
    write_period(8'($urandom_range(30, 60)));
    send_random(20);
    drain();

    // period lowered below the running count
    write_period(8'd3);
    send_random(250);
    drain();

    $display("ran %0d ticks, checked %0d frames (%0d heartbeats) over %0d period settings",
             ticks_sent, frames_seen, hb_seen, periods_written);
    if (err_count == 0) begin
      $display("tb_contactor_frame_crc8_gen_unit passed");
    end else begin
      $display("tb_contactor_frame_crc8_gen_unit failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cfcrc_pkg.sv
sv/cfcrc_front.sv
sv/cfcrc_queue.sv
sv/cfcrc_back.sv
sv/contactor_frame_crc8_gen_unit.sv
bench/tb_contactor_frame_crc8_gen_unit.sv
